// ===== sv/mcpu_pkg.sv =====
// shared types, constants, rounding and saturation helpers for the moment-corrected primitive update
package mcpu_pkg;

   localparam logic signed [47:0] CONS_LIM   = 48'sh7FFF_FFFF_FFFF;
   localparam logic signed [80:0] CONS_LIM_W = 81'sh7FFF_FFFF_FFFF;
   localparam logic [31:0]        SCALE_RESET = 32'h0001_0000;

   typedef struct packed {
      logic signed [31:0] maxwell_density;
      logic signed [31:0] maxwell_velocity;
      logic signed [31:0] maxwell_temperature;
      logic signed [31:0] pos_count;
      logic signed [31:0] neg_count;
      logic signed [31:0] pos_momentum;
      logic signed [31:0] neg_momentum;
      logic signed [31:0] pos_energy;
      logic signed [31:0] neg_energy;
      logic               last_cell;
   } req_item_type;

   typedef struct packed {
      logic signed [31:0] cell_density;
      logic signed [31:0] cell_velocity;
      logic signed [31:0] cell_temperature;
      logic               zero_density;
      logic               last_cell_out;
   } rsp_item_type;

   // conserved values of one cell, queued between front and back
   typedef struct packed {
      logic signed [47:0] density;
      logic signed [47:0] momentum;
      logic signed [47:0] energy;
      logic               zero_density;
      logic               last_cell;
   } cons_item_type;

   // round prod / 2^shift to nearest, halves away from zero
   function automatic logic signed [80:0] rnd_away(input logic signed [80:0] prod,
                                                   input int unsigned shift);
      logic [80:0] mag;
      logic [80:0] half;
      logic [80:0] res;
      mag  = prod[80] ? 81'(-prod) : 81'(prod);
      half = 81'(1) << (shift - 1);
      res  = (mag + half) >> shift;
      return prod[80] ? -$signed(res) : $signed(res);
   endfunction

   // symmetric saturation to the conserved range
   function automatic logic signed [47:0] sat48(input logic signed [80:0] val);
      logic signed [47:0] res;
      if (val > CONS_LIM_W) begin
         res = CONS_LIM;
      end else if (val < -CONS_LIM_W) begin
         res = -CONS_LIM;
      end else begin
         res = val[47:0];
      end
      return res;
   endfunction

endpackage

// ===== sv/mcpu_front.sv =====
// front pipeline: takes cell transfers and forms corrected density, momentum and energy
module mcpu_front import mcpu_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_stall,
   input  req_item_type  req_item,
   input  logic [31:0]   moment_scale,
   input  logic          queue_full,
   output logic          push,
   output cons_item_type push_item
);

   logic adv;

   // stage 1: input register
   logic         s1_valid_ff;
   req_item_type s1_item_ff;

   // stage 2: products
   logic               s2_valid_ff;
   logic signed [63:0] s2_p_mom_ff, s2_p_v2_ff;
   logic signed [65:0] s2_p_rho_ff, s2_p_dm_ff, s2_p_de_ff;
   logic signed [31:0] s2_rm_ff, s2_tm_ff;
   logic               s2_last_ff;
   logic signed [32:0] dn, dm, de, scale_s;
   logic signed [63:0] p_mom_in, p_v2_in;
   logic signed [65:0] p_rho_in, p_dm_in, p_de_in;

   // stage 3: rounded terms
   logic               s3_valid_ff;
   logic signed [47:0] s3_mom_ff, s3_rterm_ff, s3_dmterm_ff, s3_determ_ff;
   logic signed [48:0] s3_w_ff;
   logic signed [31:0] s3_rm_ff;
   logic               s3_last_ff;
   logic signed [47:0] v2_in;
   logic signed [48:0] w_in;

   // stage 4: energy partial products, density and momentum sums
   logic               s4_valid_ff;
   logic [55:0]        s4_lo_ff, s4_hi_ff;
   logic               s4_neg_ff;
   logic signed [47:0] s4_rho_ff, s4_mom_ff, s4_determ_ff;
   logic               s4_last_ff;
   logic [31:0]        rm_mag;
   logic [47:0]        w_mag;
   logic [55:0]        lo_in, hi_in;

   // stage 5: Maxwellian energy
   logic               s5_valid_ff;
   logic signed [47:0] s5_en_ff, s5_rho_ff, s5_mom_ff, s5_determ_ff;
   logic               s5_last_ff;
   logic [79:0]        en_sum;
   logic [62:0]        en_rnd;
   logic [46:0]        en_mag;
   logic signed [47:0] en_in;

   // stage 6: queue entry
   logic          s6_valid_ff;
   cons_item_type s6_item_ff;
   cons_item_type s6_item_in;

   assign adv       = !s6_valid_ff || !queue_full;
   assign req_stall = !adv;
   assign push      = s6_valid_ff && !queue_full;
   assign push_item = s6_item_ff;

   always_comb begin
      scale_s  = $signed({1'b0, moment_scale});
      dn       = 33'(s1_item_ff.pos_count) - 33'(s1_item_ff.neg_count);
      dm       = 33'(s1_item_ff.pos_momentum) - 33'(s1_item_ff.neg_momentum);
      de       = 33'(s1_item_ff.pos_energy) - 33'(s1_item_ff.neg_energy);
      p_mom_in = s1_item_ff.maxwell_density * s1_item_ff.maxwell_velocity;
      p_v2_in  = s1_item_ff.maxwell_velocity * s1_item_ff.maxwell_velocity;
      p_rho_in = scale_s * dn;
      p_dm_in  = scale_s * dm;
      p_de_in  = scale_s * de;
   end

   always_comb begin
      v2_in = 48'(rnd_away(81'(s2_p_v2_ff), 16));
      // u^2 + 3T
      w_in  = 49'(v2_in) + 49'(s2_tm_ff) + (49'(s2_tm_ff) <<< 1);
   end

   always_comb begin
      rm_mag = s3_rm_ff[31] ? 32'(-s3_rm_ff) : 32'(s3_rm_ff);
      w_mag  = s3_w_ff[48] ? 48'(-s3_w_ff) : 48'(s3_w_ff);
      lo_in  = rm_mag * w_mag[23:0];
      hi_in  = rm_mag * w_mag[47:24];
   end

   always_comb begin
      // half factor folded into the shift by 17
      en_sum = (80'(s4_hi_ff) << 24) + 80'(s4_lo_ff) + 80'(65536);
      en_rnd = 63'(en_sum >> 17);
      en_mag = (en_rnd > 63'(CONS_LIM)) ? 47'(CONS_LIM) : en_rnd[46:0];
      en_in  = s4_neg_ff ? -$signed(48'(en_mag)) : $signed(48'(en_mag));
   end

   always_comb begin
      s6_item_in.density      = s5_rho_ff;
      s6_item_in.momentum     = s5_mom_ff;
      s6_item_in.energy       = sat48(81'(s5_en_ff) + 81'(s5_determ_ff));
      s6_item_in.zero_density = (s5_rho_ff == '0);
      s6_item_in.last_cell    = s5_last_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
         s5_valid_ff <= 1'b0;
         s6_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_valid_ff <= req_valid;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
         s4_valid_ff <= s3_valid_ff;
         s5_valid_ff <= s4_valid_ff;
         s6_valid_ff <= s5_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_item_ff   <= req_item;

         s2_p_mom_ff  <= p_mom_in;
         s2_p_v2_ff   <= p_v2_in;
         s2_p_rho_ff  <= p_rho_in;
         s2_p_dm_ff   <= p_dm_in;
         s2_p_de_ff   <= p_de_in;
         s2_rm_ff     <= s1_item_ff.maxwell_density;
         s2_tm_ff     <= s1_item_ff.maxwell_temperature;
         s2_last_ff   <= s1_item_ff.last_cell;

         s3_mom_ff    <= sat48(rnd_away(81'(s2_p_mom_ff), 16));
         s3_rterm_ff  <= sat48(rnd_away(81'(s2_p_rho_ff), 16));
         s3_dmterm_ff <= sat48(rnd_away(81'(s2_p_dm_ff), 16));
         s3_determ_ff <= sat48(rnd_away(81'(s2_p_de_ff), 17));
         s3_w_ff      <= w_in;
         s3_rm_ff     <= s2_rm_ff;
         s3_last_ff   <= s2_last_ff;

         s4_lo_ff     <= lo_in;
         s4_hi_ff     <= hi_in;
         s4_neg_ff    <= s3_rm_ff[31] ^ s3_w_ff[48];
         s4_rho_ff    <= sat48(81'(s3_rm_ff) + 81'(s3_rterm_ff));
         s4_mom_ff    <= sat48(81'(s3_mom_ff) + 81'(s3_dmterm_ff));
         s4_determ_ff <= s3_determ_ff;
         s4_last_ff   <= s3_last_ff;

         s5_en_ff     <= en_in;
         s5_rho_ff    <= s4_rho_ff;
         s5_mom_ff    <= s4_mom_ff;
         s5_determ_ff <= s4_determ_ff;
         s5_last_ff   <= s4_last_ff;

         s6_item_ff   <= s6_item_in;
      end
   end

   // a finished entry waits while the queue is full
   a_hold_on_full: assert property (@(posedge clock) disable iff (reset)
      (s6_valid_ff && queue_full) |=> s6_valid_ff)
      else $error("front entry lost while queue full");

endmodule

// ===== sv/mcpu_queue.sv =====
// short queue of conserved cell values between front and back
module mcpu_queue import mcpu_pkg::*; #(
   parameter int unsigned DEPTH = 4
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          push,
   input  cons_item_type push_item,
   output logic          full,
   input  logic          pop,
   output logic          head_valid,
   output cons_item_type head_item
);

   localparam int unsigned PTR_W = $clog2(DEPTH);
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_SLOT  = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(DEPTH);

   cons_item_type    slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign full       = (count_ff == FULL_COUNT);
   assign head_valid = (count_ff != '0);
   assign head_item  = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_SLOT) ? '0 : PTR_W'(wr_ptr_ff + 1'b1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_SLOT) ? '0 : PTR_W'(rd_ptr_ff + 1'b1);
      end
      case ({push, pop})
         2'b10:   count_in = CNT_W'(count_ff + 1'b1);
         2'b01:   count_in = CNT_W'(count_ff - 1'b1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

   a_pop_not_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> head_valid)
      else $error("queue popped while empty");

   a_push_not_full: assert property (@(posedge clock) disable iff (reset)
      push |-> (count_ff != FULL_COUNT))
      else $error("queue pushed while full");

   a_count_track: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> count_ff == CNT_W'($past(count_ff) + CNT_W'($past(push))
                                           - CNT_W'($past(pop))))
      else $error("queue fill count out of step");

endmodule

// ===== sv/mcpu_back.sv =====
// back pipeline: bit-per-stage dividers, temperature and saturation of the result
module mcpu_back import mcpu_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          head_valid,
   input  cons_item_type head_item,
   output logic          pop,
   output logic          rsp_valid,
   input  logic          rsp_stall,
   output rsp_item_type  rsp_item
);

   localparam int unsigned U_STEPS = 33;
   localparam int unsigned T_STEPS = 48;
   localparam logic [34:0] RECIP3  = 35'd22906492246;
   localparam logic [49:0] BIG3    = 50'd6442450944;

   typedef struct packed {
      logic                   valid;
      logic                   zero;
      logic                   last;
      logic signed [31:0]     density;
      logic [46:0]            divisor;
      logic                   u_neg;
      logic                   u_ovf;
      logic [46:0]            u_rem;
      logic [U_STEPS-1:0]     u_num;
      logic [U_STEPS-1:0]     u_quo;
      logic                   t_neg;
      logic                   t_ovf;
      logic [46:0]            t_rem;
      logic [T_STEPS-1:0]     t_num;
      logic [T_STEPS-1:0]     t_quo;
   } div_stage_type;

   logic adv;

   div_stage_type st_ff [0:T_STEPS];
   div_stage_type st_in [0:T_STEPS];

   logic [47:0] rho_mag, mom_mag, en_mag;
   logic [62:0] num_u;
   logic [63:0] num_t;

   // rounding stage
   logic               r_valid_ff, r_zero_ff, r_last_ff;
   logic signed [31:0] r_u_ff, r_density_ff;
   logic signed [49:0] r_q_ff;
   logic [33:0]        u_qr;
   logic [48:0]        t_qr;
   logic [47:0]        t_qmag;
   logic signed [31:0] u_in;
   logic signed [49:0] q_in;

   // u^2 product stage
   logic               m1_valid_ff, m1_zero_ff, m1_last_ff;
   logic signed [31:0] m1_u_ff, m1_density_ff;
   logic signed [49:0] m1_q_ff;
   logic signed [63:0] m1_v2p_ff;

   // difference stage
   logic               m2_valid_ff, m2_zero_ff, m2_last_ff;
   logic signed [31:0] m2_u_ff, m2_density_ff;
   logic signed [50:0] m2_diff_ff;
   logic signed [47:0] v2_in;

   // magnitude stage
   logic               m3_valid_ff, m3_zero_ff, m3_last_ff, m3_neg_ff, m3_big_ff;
   logic signed [31:0] m3_u_ff, m3_density_ff;
   logic [33:0]        m3_x_ff;
   logic [49:0]        d_mag;

   // divide by three stage
   logic               m4_valid_ff, m4_zero_ff, m4_last_ff, m4_neg_ff, m4_big_ff;
   logic signed [31:0] m4_u_ff, m4_density_ff;
   logic [68:0]        m4_prod_ff;

   logic [32:0]        f_mag;
   logic signed [31:0] t_in;
   logic               rsp_valid_ff;
   rsp_item_type       rsp_item_ff, rsp_item_in;

   assign adv       = !rsp_valid_ff || !rsp_stall;
   assign pop       = adv && head_valid;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

   // divider set-up: magnitudes, first partial remainders, overflow checks
   always_comb begin
      rho_mag = head_item.density[47] ? 48'(-head_item.density) : 48'(head_item.density);
      mom_mag = head_item.momentum[47] ? 48'(-head_item.momentum) : 48'(head_item.momentum);
      en_mag  = head_item.energy[47] ? 48'(-head_item.energy) : 48'(head_item.energy);
      num_u   = {mom_mag[46:0], 16'b0};
      num_t   = {en_mag[46:0], 17'b0};

      st_in[0].valid   = head_valid;
      st_in[0].zero    = head_item.zero_density;
      st_in[0].last    = head_item.last_cell;
      if (head_item.density > 48'sh0000_7FFF_FFFF) begin
         st_in[0].density = 32'sh7FFF_FFFF;
      end else if (head_item.density < -48'sh0000_8000_0000) begin
         st_in[0].density = 32'sh8000_0000;
      end else begin
         st_in[0].density = head_item.density[31:0];
      end
      st_in[0].divisor = rho_mag[46:0];
      st_in[0].u_neg   = head_item.momentum[47] ^ head_item.density[47];
      st_in[0].u_ovf   = 47'(num_u[62:U_STEPS]) >= rho_mag[46:0];
      st_in[0].u_rem   = 47'(num_u[62:U_STEPS]);
      st_in[0].u_num   = num_u[U_STEPS-1:0];
      st_in[0].u_quo   = '0;
      st_in[0].t_neg   = head_item.energy[47] ^ head_item.density[47];
      st_in[0].t_ovf   = 47'(num_t[63:T_STEPS]) >= rho_mag[46:0];
      st_in[0].t_rem   = 47'(num_t[63:T_STEPS]);
      st_in[0].t_num   = num_t[T_STEPS-1:0];
      st_in[0].t_quo   = '0;
   end

   // one t quotient bit per stage, and one u bit per stage in the first U_STEPS only
   for (genvar k = 0; k < T_STEPS; k++) begin : g_step
      logic [47:0] t_trial;
      logic [47:0] u_trial;
      always_comb begin
         st_in[k+1] = st_ff[k];
         t_trial = {st_ff[k].t_rem, st_ff[k].t_num[T_STEPS-1]};
         u_trial = {st_ff[k].u_rem, st_ff[k].u_num[U_STEPS-1]};
         st_in[k+1].t_num = {st_ff[k].t_num[T_STEPS-2:0], 1'b0};
         if (t_trial >= {1'b0, st_ff[k].divisor}) begin
            st_in[k+1].t_rem = 47'(t_trial - {1'b0, st_ff[k].divisor});
            st_in[k+1].t_quo = {st_ff[k].t_quo[T_STEPS-2:0], 1'b1};
         end else begin
            st_in[k+1].t_rem = t_trial[46:0];
            st_in[k+1].t_quo = {st_ff[k].t_quo[T_STEPS-2:0], 1'b0};
         end
         if (k < U_STEPS) begin
            st_in[k+1].u_num = {st_ff[k].u_num[U_STEPS-2:0], 1'b0};
            if (u_trial >= {1'b0, st_ff[k].divisor}) begin
               st_in[k+1].u_rem = 47'(u_trial - {1'b0, st_ff[k].divisor});
               st_in[k+1].u_quo = {st_ff[k].u_quo[U_STEPS-2:0], 1'b1};
            end else begin
               st_in[k+1].u_rem = u_trial[46:0];
               st_in[k+1].u_quo = {st_ff[k].u_quo[U_STEPS-2:0], 1'b0};
            end
         end
      end
   end

   // round halves away from zero and saturate the quotients
   always_comb begin
      u_qr = 34'(st_ff[T_STEPS].u_quo)
           + 34'({st_ff[T_STEPS].u_rem, 1'b0} >= {1'b0, st_ff[T_STEPS].divisor});
      t_qr = 49'(st_ff[T_STEPS].t_quo)
           + 49'({st_ff[T_STEPS].t_rem, 1'b0} >= {1'b0, st_ff[T_STEPS].divisor});
      if (st_ff[T_STEPS].u_ovf || (u_qr[33:31] != 3'b000)) begin
         u_in = st_ff[T_STEPS].u_neg ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
      end else begin
         u_in = st_ff[T_STEPS].u_neg ? -$signed(u_qr[31:0]) : $signed(u_qr[31:0]);
      end
      // beyond 2^48 the temperature saturates either way
      t_qmag = (st_ff[T_STEPS].t_ovf || t_qr[48]) ? '1 : t_qr[47:0];
      q_in   = st_ff[T_STEPS].t_neg ? -$signed(50'(t_qmag)) : $signed(50'(t_qmag));
   end

   always_comb begin
      v2_in = 48'(rnd_away(81'(m1_v2p_ff), 16));
      d_mag = m2_diff_ff[50] ? 50'(-m2_diff_ff) : 50'(m2_diff_ff);
   end

   always_comb begin
      f_mag = m4_prod_ff[68:36];
      if (m4_big_ff || (f_mag[32:31] != 2'b00)) begin
         t_in = m4_neg_ff ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
      end else begin
         t_in = m4_neg_ff ? -$signed(f_mag[31:0]) : $signed(f_mag[31:0]);
      end
      rsp_item_in.cell_density     = m4_density_ff;
      rsp_item_in.cell_velocity    = m4_zero_ff ? '0 : m4_u_ff;
      rsp_item_in.cell_temperature = m4_zero_ff ? '0 : t_in;
      rsp_item_in.zero_density     = m4_zero_ff;
      rsp_item_in.last_cell_out    = m4_last_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i <= T_STEPS; i++) begin
            st_ff[i].valid <= 1'b0;
         end
         r_valid_ff   <= 1'b0;
         m1_valid_ff  <= 1'b0;
         m2_valid_ff  <= 1'b0;
         m3_valid_ff  <= 1'b0;
         m4_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         for (int i = 0; i <= T_STEPS; i++) begin
            st_ff[i] <= st_in[i];
         end
         r_valid_ff   <= st_ff[T_STEPS].valid;
         m1_valid_ff  <= r_valid_ff;
         m2_valid_ff  <= m1_valid_ff;
         m3_valid_ff  <= m2_valid_ff;
         m4_valid_ff  <= m3_valid_ff;
         rsp_valid_ff <= m4_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         r_u_ff        <= u_in;
         r_q_ff        <= q_in;
         r_density_ff  <= st_ff[T_STEPS].density;
         r_zero_ff     <= st_ff[T_STEPS].zero;
         r_last_ff     <= st_ff[T_STEPS].last;

         m1_v2p_ff     <= r_u_ff * r_u_ff;
         m1_u_ff       <= r_u_ff;
         m1_q_ff       <= r_q_ff;
         m1_density_ff <= r_density_ff;
         m1_zero_ff    <= r_zero_ff;
         m1_last_ff    <= r_last_ff;

         m2_diff_ff    <= 51'(m1_q_ff) - 51'(v2_in);
         m2_u_ff       <= m1_u_ff;
         m2_density_ff <= m1_density_ff;
         m2_zero_ff    <= m1_zero_ff;
         m2_last_ff    <= m1_last_ff;

         // round(m/3) is floor((m+1)/3) for whole m
         m3_neg_ff     <= m2_diff_ff[50];
         m3_big_ff     <= d_mag >= BIG3;
         m3_x_ff       <= 34'(d_mag[32:0]) + 34'd1;
         m3_u_ff       <= m2_u_ff;
         m3_density_ff <= m2_density_ff;
         m3_zero_ff    <= m2_zero_ff;
         m3_last_ff    <= m2_last_ff;

         m4_prod_ff    <= m3_x_ff * RECIP3;
         m4_neg_ff     <= m3_neg_ff;
         m4_big_ff     <= m3_big_ff;
         m4_u_ff       <= m3_u_ff;
         m4_density_ff <= m3_density_ff;
         m4_zero_ff    <= m3_zero_ff;
         m4_last_ff    <= m3_last_ff;

         rsp_item_ff   <= rsp_item_in;
      end
   end

   a_zero_forces: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_item_ff.zero_density) |->
         (rsp_item_ff.cell_velocity == '0) && (rsp_item_ff.cell_temperature == '0))
      else $error("zero density result carries velocity or temperature");

endmodule

// ===== sv/moment_corrected_primitive_update.sv =====
// throughput: one cell per cycle while neither a full queue nor rsp_stall holds the flow; the front
// pipeline, queue and the bit-per-stage dividers of the back pipeline then all advance every cycle
// a stalled result holds the back pipeline; the queue lets the front keep going until it is full
// reset (synchronous) empties all stages and the queue and sets moment_scale to 1.0
module moment_corrected_primitive_update import mcpu_pkg::*; #(
   parameter int unsigned QUEUE_DEPTH = 4
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  req_item_type req_item,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_item_type rsp_item,
   input  logic         csr_write_enable,
   input  logic [31:0]  csr_write_data
);

   logic [31:0]   moment_scale_ff;
   logic          queue_full, push, pop, head_valid;
   cons_item_type push_item, head_item;

   always_ff @(posedge clock) begin
      if (reset) begin
         moment_scale_ff <= SCALE_RESET;
      end else if (csr_write_enable) begin
         moment_scale_ff <= csr_write_data;
      end
   end

   mcpu_front u_front (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_item     (req_item),
      .moment_scale (moment_scale_ff),
      .queue_full   (queue_full),
      .push         (push),
      .push_item    (push_item)
   );

   mcpu_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_item  (push_item),
      .full       (queue_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_item  (head_item)
   );

   mcpu_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_item  (head_item),
      .pop        (pop),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_item   (rsp_item)
   );

endmodule

// ===== tb/sv/tb_moment_corrected_primitive_update.sv =====
// testbench for moment_corrected_primitive_update: directed table, random cells, bit-exact predictor
module tb_moment_corrected_primitive_update;
   import mcpu_pkg::*;

   localparam int LATENCY     = 61;
   localparam int CYCLE_LIMIT = 400000;
   localparam int N_RANDOM    = 800;
   localparam int N_DIRECTED  = 14;

   localparam logic [63:0] LIM_CONS = 64'h0000_7FFF_FFFF_FFFF;
   localparam logic [63:0] LIM_WIDE = 64'h3FFF_FFFF_FFFF_FFFF;

   logic         clock;
   logic         reset;
   logic         req_valid;
   logic         req_stall;
   req_item_type req_item;
   logic         rsp_valid;
   logic         rsp_stall;
   rsp_item_type rsp_item;
   logic         csr_write_enable;
   logic [31:0]  csr_write_data;

   moment_corrected_primitive_update uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_item(req_item),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_item(rsp_item),
      .csr_write_enable(csr_write_enable), .csr_write_data(csr_write_data)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   logic [31:0]  scale_shadow;
   rsp_item_type expected_cells[$];
   int           mismatches;
   int           cells_sent;
   int           cells_checked;
   int           zero_cells;
   int           cycle_count;
   bit           stall_burst;

   function automatic logic [63:0] magnitude(input logic signed [63:0] v);
      return v[63] ? 64'(-v) : 64'(v);
   endfunction

   function automatic logic signed [63:0] apply_sign(input logic [63:0] m, input bit neg);
      return neg ? -$signed(m) : $signed(m);
   endfunction

   function automatic logic signed [63:0] clip_sym(input logic signed [63:0] v,
                                                   input logic [63:0] lim);
      logic signed [63:0] res;
      res = v;
      if (v > $signed(lim)) res = $signed(lim);
      if (v < -$signed(lim)) res = -$signed(lim);
      return res;
   endfunction

   function automatic logic signed [31:0] clip32(input logic signed [63:0] v);
      logic signed [31:0] res;
      if (v > 64'sd2147483647) res = 32'sh7FFF_FFFF;
      else if (v < -64'sd2147483648) res = 32'sh8000_0000;
      else res = v[31:0];
      return res;
   endfunction

   // rounded, shifted product with halves away from zero, saturating on magnitude
   function automatic logic signed [63:0] scaled_product(input logic signed [63:0] a,
                                                         input logic signed [63:0] b,
                                                         input int sh,
                                                         input logic [63:0] lim);
      logic [127:0] p;
      logic [127:0] r;
      logic [63:0]  m;
      p = 128'(magnitude(a)) * 128'(magnitude(b));
      r = (p + (128'(1) << (sh - 1))) >> sh;
      m = (r > 128'(lim)) ? lim : r[63:0];
      return apply_sign(m, a[63] != b[63]);
   endfunction

   function automatic logic signed [63:0] scaled_quotient(input logic signed [63:0] n,
                                                          input logic signed [63:0] d,
                                                          input int sh,
                                                          input logic [63:0] lim);
      logic [127:0] num;
      logic [127:0] q;
      logic [127:0] rem;
      logic [127:0] ud;
      logic [63:0]  m;
      ud = 128'(magnitude(d));
      if (ud == 0) return 64'sd0;
      num = 128'(magnitude(n)) << sh;
      q   = num / ud;
      rem = num % ud;
      if (rem >= ud - rem) q = q + 1;
      m = (q > 128'(lim)) ? lim : q[63:0];
      return apply_sign(m, n[63] != d[63]);
   endfunction

   function automatic rsp_item_type predict_cell(input req_item_type c, input logic [31:0] sc);
      rsp_item_type       r;
      logic signed [63:0] s, rm, um, tm, dn, dm, de, mom, en, rho, u, t, v2, q;
      s  = $signed({32'd0, sc});
      rm = 64'(c.maxwell_density);
      um = 64'(c.maxwell_velocity);
      tm = 64'(c.maxwell_temperature);
      dn = 64'(c.pos_count) - 64'(c.neg_count);
      dm = 64'(c.pos_momentum) - 64'(c.neg_momentum);
      de = 64'(c.pos_energy) - 64'(c.neg_energy);
      mom = scaled_product(rm, um, 16, LIM_CONS);
      v2  = scaled_product(um, um, 16, LIM_WIDE);
      en  = scaled_product(rm, v2 + 3 * tm, 17, LIM_CONS);
      rho = clip_sym(rm + scaled_product(s, dn, 16, LIM_CONS), LIM_CONS);
      mom = clip_sym(mom + scaled_product(s, dm, 16, LIM_CONS), LIM_CONS);
      en  = clip_sym(en + scaled_product(s, de, 17, LIM_CONS), LIM_CONS);
      u = 0;
      t = 0;
      if (rho != 0) begin
         u  = clip32(scaled_quotient(mom, rho, 16, LIM_WIDE));
         q  = scaled_quotient(en, rho, 17, LIM_WIDE);
         v2 = scaled_product(u, u, 16, LIM_WIDE);
         t  = clip32(scaled_quotient(q - v2, 3, 0, LIM_WIDE));
      end
      r.cell_density     = clip32(rho);
      r.cell_velocity    = u[31:0];
      r.cell_temperature = t[31:0];
      r.zero_density     = (rho == 0);
      r.last_cell_out    = c.last_cell;
      return r;
   endfunction

   // favour small physical values with the odd full-range word
   function automatic logic [31:0] pick_word();
      logic [31:0] w;
      case ($urandom_range(0, 9))
         0: w = $urandom();
         1: w = 32'h7FFF_FFFF;
         2: w = 32'h8000_0000;
         3, 4: w = $urandom_range(0, 32'h0010_0000);
         5: w = -$urandom_range(0, 32'h0010_0000);
         default: w = $signed($urandom_range(0, 32'h0080_0000)) - 32'sh0040_0000;
      endcase
      return w;
   endfunction

   function automatic req_item_type random_cell();
      req_item_type c;
      c.maxwell_density     = pick_word();
      c.maxwell_velocity    = pick_word();
      c.maxwell_temperature = pick_word();
      c.pos_count           = pick_word();
      c.neg_count           = pick_word();
      c.pos_momentum        = pick_word();
      c.neg_momentum        = pick_word();
      c.pos_energy          = pick_word();
      c.neg_energy          = pick_word();
      c.last_cell           = $urandom_range(0, 1);
      // force the zero-density path now and then
      if ($urandom_range(0, 15) == 0) begin
         c.pos_count       = c.neg_count;
         c.maxwell_density = 0;
      end
      return c;
   endfunction

   // receiver stall pattern: bursts of stalling and runs without any
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if ($urandom_range(0, 15) == 0) stall_burst = !stall_burst;
         rsp_stall <= stall_burst ? ($urandom_range(0, 2) != 0) : 1'b0;
      end
   end

   always @(posedge clock) begin
      rsp_item_type e;
      cycle_count <= cycle_count + 1;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_cells.size() == 0) begin
            mismatches = mismatches + 1;
            if (mismatches <= 10) $display("unexpected result transfer %p", rsp_item);
         end else begin
            e = expected_cells.pop_front();
            cells_checked = cells_checked + 1;
            if (e.zero_density) zero_cells = zero_cells + 1;
            if (rsp_item !== e) begin
               mismatches = mismatches + 1;
               if (mismatches <= 10)
                  $display("cell %0d mismatch: expected %p, got %p", cells_checked, e, rsp_item);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout with %0d results outstanding", expected_cells.size());
         $display("tb_moment_corrected_primitive_update: FAIL");
         $finish;
      end
   end

   task automatic send_cell(input req_item_type c);
      req_valid <= 1'b1;
      req_item  <= c;
      expected_cells.push_back(predict_cell(c, scale_shadow));
      @(posedge clock);
      while (req_stall) @(posedge clock);
      cells_sent = cells_sent + 1;
      @(negedge clock);
   endtask

   // the caller has already dropped req_valid
   task automatic drain_and_set_scale(input logic [31:0] v);
      while (expected_cells.size() != 0) @(negedge clock);
      repeat (LATENCY) @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= v;
      scale_shadow = v;
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   task automatic run_random(input int n);
      int burst;
      while (n > 0) begin
         burst = $urandom_range(1, 24);
         while (burst > 0 && n > 0) begin
            send_cell(random_cell());
            burst--;
            n--;
         end
         if ($urandom_range(0, 3) != 0) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clock);
         end
      end
      req_valid <= 1'b0;
   endtask

   req_item_type directed_cells[N_DIRECTED];
   rsp_item_type directed_known[N_DIRECTED];
   bit           directed_has_known[N_DIRECTED];

   initial begin
      req_item_type c;
      rsp_item_type k;
      logic [31:0]  scales[5];
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_item         = '0;
      rsp_stall        = 1'b0;
      csr_write_enable = 1'b0;
      csr_write_data   = '0;
      mismatches       = 0;
      cells_sent       = 0;
      cells_checked    = 0;
      zero_cells       = 0;
      cycle_count      = 0;
      stall_burst      = 1'b0;
      scale_shadow     = SCALE_RESET;
      scales = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_8000, 32'h0003_0000, 32'h0001_0000};

      for (int i = 0; i < N_DIRECTED; i++) begin
         c = '0;
         k = '0;
         directed_has_known[i] = 1'b0;
         case (i)
            0: begin
               // all zero: zero density, flag set
               k.zero_density = 1'b1;
               directed_has_known[i] = 1'b1;
            end
            1: begin
               // unit density at rest, last cell flag carried
               c.maxwell_density = 32'sh0001_0000;
               c.last_cell = 1'b1;
               k.cell_density = 32'sh0001_0000;
               k.last_cell_out = 1'b1;
               directed_has_known[i] = 1'b1;
            end
            2: begin
               // particles cancel the Maxwellian exactly
               c.maxwell_density = 32'sh0002_0000;
               c.neg_count = 32'sh0002_0000;
               c.maxwell_velocity = 32'sh0005_0000;
               k.zero_density = 1'b1;
               directed_has_known[i] = 1'b1;
            end
            3: begin
               c.maxwell_density = 32'sh7FFF_FFFF;
               c.pos_count = 32'sh7FFF_FFFF;
               c.neg_count = 32'sh8000_0000;
            end
            4: begin
               c.maxwell_density = 32'sh8000_0000;
               c.maxwell_velocity = 32'sh7FFF_FFFF;
               c.maxwell_temperature = 32'sh7FFF_FFFF;
            end
            5: begin
               // negative density, signed divide
               c.maxwell_density = -32'sh0001_0000;
               c.maxwell_velocity = 32'sh0003_0000;
               c.maxwell_temperature = 32'sh0001_8000;
            end
            6: begin
               c.maxwell_density = 32'sh0000_0001;
               c.maxwell_velocity = 32'sh8000_0000;
               c.maxwell_temperature = 32'sh8000_0000;
            end
            7: begin
               c.maxwell_density = 32'sh0001_0000;
               c.pos_momentum = 32'sh7FFF_FFFF;
               c.neg_momentum = 32'sh8000_0000;
               c.pos_energy = 32'sh7FFF_FFFF;
               c.neg_energy = 32'sh8000_0000;
            end
            8: begin
               c.maxwell_density = 32'sh0000_0003;
               c.maxwell_velocity = 32'sh0000_0001;
               c.maxwell_temperature = 32'sh0000_0001;
               c.pos_count = 32'sh0000_0001;
            end
            9: begin
               c = '1;
            end
            10: begin
               c.maxwell_density = 32'sh0004_0000;
               c.maxwell_velocity = -32'sh0002_0000;
               c.maxwell_temperature = 32'sh0000_8000;
               c.pos_count = 32'sh0001_0000;
               c.neg_momentum = 32'sh0003_0000;
               c.pos_energy = 32'sh0007_0000;
            end
            default: c = random_cell();
         endcase
         directed_cells[i] = c;
         directed_known[i] = k;
      end

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      for (int i = 0; i < N_DIRECTED; i++) begin
         if (directed_has_known[i] &&
             predict_cell(directed_cells[i], scale_shadow) !== directed_known[i]) begin
            mismatches = mismatches + 1;
            $display("row %0d: typed result disagrees with prediction", i);
         end
         send_cell(directed_cells[i]);
      end
      req_valid <= 1'b0;

      foreach (scales[j]) begin
         drain_and_set_scale(scales[j]);
         for (int i = 0; i < N_DIRECTED; i++) send_cell(directed_cells[i]);
         run_random(N_RANDOM / 5);
      end

      while (expected_cells.size() != 0) @(negedge clock);
      repeat (LATENCY + 10) @(negedge clock);
      $display("sent %0d cells over %0d scale settings, checked %0d results (%0d zero density)",
               cells_sent, 6, cells_checked, zero_cells);
      if (mismatches == 0) begin
         $display("tb_moment_corrected_primitive_update: PASS");
      end else begin
         $display("%0d mismatches", mismatches);
         $display("tb_moment_corrected_primitive_update: FAIL");
      end
      $finish;
   end

endmodule
